/* sv/tcg_pkg.sv */
// ---------------------------------------------------------------------------
// tcg_pkg
// Shared types, codes and sizes for the text console glyph writer.
// ---------------------------------------------------------------------------
package tcg_pkg;

    localparam int MAX_COLUMNS     = 128;
    localparam int MAX_ROWS        = 64;
    localparam int GLYPH_WIDTH     = 8;
    localparam int GLYPH_ROWS_MAX  = 16;
    localparam int CHARACTER_COUNT = 256;

    localparam int FONT_DEPTH  = CHARACTER_COUNT * GLYPH_ROWS_MAX;
    localparam int FONT_AW     = $clog2(FONT_DEPTH);
    localparam int ROW_IDX_W   = $clog2(GLYPH_ROWS_MAX);
    localparam int GLYPH_SHIFT = $clog2(GLYPH_WIDTH);
    localparam int UNIT_W      = 10;

    // operation codes
    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_GLYPH  = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;

    // control characters
    localparam logic [7:0] CODE_LF = 8'd10;
    localparam logic [7:0] CODE_CR = 8'd13;

    // configuration register indexes
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_HEIGHT  = 2'd2;

    typedef struct packed {
        logic [7:0] eff_cols;
        logic [6:0] eff_rows;
        logic [4:0] height;
    } cfg_t;

    typedef struct packed {
        logic               rd_en;
        logic [FONT_AW-1:0] rd_addr;
        logic               wr_en;
        logic [FONT_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
    } font_ctl_t;

endpackage

/* sv/tcg_if.sv */
// ---------------------------------------------------------------------------
// tcg_if
// Request and response channels of the glyph writer, valid/ready.
// ---------------------------------------------------------------------------
interface tcg_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [6:0]  column_target;
    logic [5:0]  row_target;
    logic [11:0] font_address;
    logic [7:0]  font_byte;

    modport source (
        output valid, operation, char_code, column_target, row_target,
               font_address, font_byte,
        input  ready
    );

    modport sink (
        input  valid, operation, char_code, column_target, row_target,
               font_address, font_byte,
        output ready
    );
endinterface

interface tcg_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] row_mask;
    logic       last;

    modport source (
        output valid, kind, pixel_x, pixel_y, row_mask, last,
        input  ready
    );

    modport sink (
        input  valid, kind, pixel_x, pixel_y, row_mask, last,
        output ready
    );
endinterface

/* sv/text_console_glyph_writer_core.sv */
// ---------------------------------------------------------------------------
// text_console_glyph_writer_core
// Put character with h glyph rows: ST_CHK_COL, ST_CHK_ROW, ST_BASE, then
// ST_EMIT sends one row per cycle while the output is free, paced by the
// single font store read port; a scroll adds ST_FINAL. Set cursor: CHK_COL,
// CHK_ROW, FINAL; line feed: CHK_ROW, FINAL; CR and font load: FINAL.
// Reset: cursor to 0,0, registers to 80 columns, 25 rows, height 16; the
// font store is not cleared and must be loaded before use.
// ---------------------------------------------------------------------------
module text_console_glyph_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    tcg_req_if.sink     req,
    tcg_rsp_if.source   rsp
);

    logic [7:0] columns_reg, columns_next;
    logic [6:0] rows_reg, rows_next;
    logic [4:0] height_reg, height_next;

    tcg_pkg::cfg_t      cfg;
    tcg_pkg::font_ctl_t font_ctl;
    logic [7:0]         font_data;

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        height_next  = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tcg_pkg::REG_COLUMNS: columns_next = cfg_data;
                tcg_pkg::REG_ROWS:    rows_next    = cfg_data[6:0];
                tcg_pkg::REG_HEIGHT:  height_next  = cfg_data[4:0];
                default:
                begin
                    columns_next = columns_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= 8'd80;
            rows_reg    <= 7'd25;
            height_reg  <= 5'd16;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
            height_reg  <= height_next;
        end
    end

    // clamp to the supported screen and glyph sizes
    always_comb
    begin
        cfg.eff_cols = (columns_reg > 8'(tcg_pkg::MAX_COLUMNS))
                       ? 8'(tcg_pkg::MAX_COLUMNS) : columns_reg;
        cfg.eff_rows = (rows_reg > 7'(tcg_pkg::MAX_ROWS))
                       ? 7'(tcg_pkg::MAX_ROWS) : rows_reg;
        cfg.height   = (height_reg > 5'(tcg_pkg::GLYPH_ROWS_MAX))
                       ? 5'(tcg_pkg::GLYPH_ROWS_MAX) : height_reg;
    end

    tcg_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .rsp       (rsp),
        .font_ctl  (font_ctl),
        .font_data (font_data)
    );

    tcg_font_ram u_font_ram (
        .clk     (clk),
        .ctl     (font_ctl),
        .rd_data (font_data)
    );

endmodule

/* sv/tcg_add_cmp.sv */
// ---------------------------------------------------------------------------
// tcg_add_cmp
// Shared add-and-compare unit: sum = a + b, ge = (sum >= c).
// ---------------------------------------------------------------------------
module tcg_add_cmp (
    input  logic [tcg_pkg::UNIT_W-1:0] a,
    input  logic [tcg_pkg::UNIT_W-1:0] b,
    input  logic [tcg_pkg::UNIT_W-1:0] c,
    output logic [tcg_pkg::UNIT_W:0]   sum,
    output logic                       ge
);

    assign sum = {1'b0, a} + {1'b0, b};
    assign ge  = sum >= {1'b0, c};

endmodule

/* sv/tcg_font_ram.sv */
// ---------------------------------------------------------------------------
// tcg_font_ram
// Font store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module tcg_font_ram (
    input  logic                 clk,
    input  tcg_pkg::font_ctl_t   ctl,
    output logic [7:0]           rd_data
);

    logic [7:0] mem [tcg_pkg::FONT_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/tcg_engine.sv */
// ---------------------------------------------------------------------------
// tcg_engine
// Sequencer: decodes a transaction, runs the range and wrap checks and the
// row address steps through the shared unit, reads the font store once per
// glyph row and drives the response register.
// ---------------------------------------------------------------------------
module tcg_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcg_pkg::cfg_t        cfg,
    tcg_req_if.sink              req,
    tcg_rsp_if.source            rsp,
    output tcg_pkg::font_ctl_t   font_ctl,
    input  logic [7:0]           font_data
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_CHK_COL = 6'b000010,
        ST_CHK_ROW = 6'b000100,
        ST_BASE    = 6'b001000,
        ST_EMIT    = 6'b010000,
        ST_FINAL   = 6'b100000
    } state_t;

    localparam int UW = tcg_pkg::UNIT_W;
    localparam int RW = tcg_pkg::ROW_IDX_W;

    state_t      state_reg, state_next;
    logic [7:0]  code_reg, code_next;
    logic [6:0]  cx_reg, cx_next;
    logic [5:0]  cy_reg, cy_next;
    logic        is_set_reg, is_set_next;
    logic        is_lf_reg, is_lf_next;
    logic [6:0]  col_reg, col_next;
    logic [5:0]  row_reg, row_next;
    logic        col_ge_reg, col_ge_next;
    logic        row_ge_reg, row_ge_next;
    logic        scroll_reg, scroll_next;
    logic [1:0]  final_kind_reg, final_kind_next;
    logic [9:0]  x_reg, x_next;
    logic [9:0]  y_reg, y_next;
    logic [4:0]  idx_reg, idx_next;

    logic        rsp_valid_reg, rsp_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [9:0]  px_reg, px_next;
    logic [9:0]  py_reg, py_next;
    logic [7:0]  mask_reg, mask_next;
    logic        last_reg, last_next;

    logic [UW-1:0] unit_a, unit_b, unit_c;
    logic [UW:0]   unit_sum;
    logic          unit_ge;

    logic        accept;
    logic        out_free;
    logic [4:0]  idx_inc;
    logic        row_last;

    tcg_add_cmp u_add_cmp (
        .a   (unit_a),
        .b   (unit_b),
        .c   (unit_c),
        .sum (unit_sum),
        .ge  (unit_ge)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign idx_inc   = idx_reg + 5'd1;
    assign row_last  = (idx_inc == cfg.height);

    // shared unit operand selection
    always_comb
    begin
        unit_a = y_reg;
        unit_b = UW'(1);
        unit_c = '0;
        case (state_reg)
            ST_CHK_COL:
            begin
                unit_a = is_set_reg ? UW'(cx_reg) : UW'(col_reg);
                unit_b = is_set_reg ? UW'(0) : UW'(1);
                unit_c = UW'(cfg.eff_cols);
            end
            ST_CHK_ROW:
            begin
                unit_a = is_set_reg ? UW'(cy_reg) : UW'(row_reg);
                unit_b = is_set_reg ? UW'(0) : UW'(2);
                unit_c = UW'(cfg.eff_rows);
            end
            default:
            begin
                unit_a = y_reg;
                unit_b = UW'(1);
                unit_c = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        code_next       = code_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        is_set_next     = is_set_reg;
        is_lf_next      = is_lf_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        col_ge_next     = col_ge_reg;
        row_ge_next     = row_ge_reg;
        scroll_next     = scroll_reg;
        final_kind_next = final_kind_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        idx_next        = idx_reg;

        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        kind_next       = kind_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        mask_next       = mask_reg;
        last_next       = last_reg;

        font_ctl.rd_en   = 1'b0;
        font_ctl.rd_addr = {code_reg, idx_inc[RW-1:0]};
        font_ctl.wr_en   = accept && (req.operation == tcg_pkg::OP_LOAD);
        font_ctl.wr_addr = req.font_address[tcg_pkg::FONT_AW-1:0];
        font_ctl.wr_data = req.font_byte;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    code_next       = req.char_code;
                    cx_next         = req.column_target;
                    cy_next         = req.row_target;
                    is_set_next     = (req.operation == tcg_pkg::OP_SET);
                    is_lf_next      = (req.operation == tcg_pkg::OP_PUT)
                                      && (req.char_code == tcg_pkg::CODE_LF);
                    final_kind_next = tcg_pkg::KIND_ACK;
                    if (req.operation == tcg_pkg::OP_SET)
                    begin
                        state_next = ST_CHK_COL;
                    end
                    else if (req.operation == tcg_pkg::OP_PUT)
                    begin
                        if (req.char_code == tcg_pkg::CODE_LF)
                        begin
                            state_next = ST_CHK_ROW;
                        end
                        else if (req.char_code == tcg_pkg::CODE_CR)
                        begin
                            col_next   = '0;
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            state_next = ST_CHK_COL;
                        end
                    end
                    else
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end

            ST_CHK_COL:
            begin
                col_ge_next = unit_ge;
                state_next  = ST_CHK_ROW;
            end

            ST_CHK_ROW:
            begin
                if (is_set_reg)
                begin
                    if (!col_ge_reg && !unit_ge)
                    begin
                        col_next = cx_reg;
                        row_next = cy_reg;
                    end
                    state_next = ST_FINAL;
                end
                else if (is_lf_reg)
                begin
                    col_next = '0;
                    if (unit_ge)
                    begin
                        final_kind_next = tcg_pkg::KIND_SCROLL;
                    end
                    else
                    begin
                        row_next = row_reg + 6'd1;
                    end
                    state_next = ST_FINAL;
                end
                else
                begin
                    row_ge_next = unit_ge;
                    scroll_next = col_ge_reg && unit_ge;
                    state_next  = ST_BASE;
                end
            end

            ST_BASE:
            begin
                x_next   = 10'(col_reg) << tcg_pkg::GLYPH_SHIFT;
                y_next   = 10'(row_reg) * 10'(cfg.height);
                idx_next = '0;
                font_ctl.rd_en   = 1'b1;
                font_ctl.rd_addr = {code_reg, {RW{1'b0}}};
                // cursor advance with wrap
                if (col_ge_reg)
                begin
                    col_next = '0;
                    if (!row_ge_reg)
                    begin
                        row_next = row_reg + 6'd1;
                    end
                end
                else
                begin
                    col_next = col_reg + 7'd1;
                end
                final_kind_next = scroll_reg ? tcg_pkg::KIND_SCROLL : tcg_pkg::KIND_ACK;
                state_next = (cfg.height == 5'd0) ? ST_FINAL : ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    kind_next      = tcg_pkg::KIND_GLYPH;
                    px_next        = x_reg;
                    py_next        = y_reg;
                    mask_next      = font_data;
                    last_next      = row_last && !scroll_reg;
                    y_next         = unit_sum[UW-1:0];
                    idx_next       = idx_inc;
                    if (row_last)
                    begin
                        state_next = scroll_reg ? ST_FINAL : ST_IDLE;
                    end
                    else
                    begin
                        font_ctl.rd_en = 1'b1;
                    end
                end
            end

            ST_FINAL:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    kind_next      = final_kind_reg;
                    px_next        = '0;
                    py_next        = '0;
                    mask_next      = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg       <= code_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        is_set_reg     <= is_set_next;
        is_lf_reg      <= is_lf_next;
        col_ge_reg     <= col_ge_next;
        row_ge_reg     <= row_ge_next;
        scroll_reg     <= scroll_next;
        final_kind_reg <= final_kind_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        idx_reg        <= idx_next;
        kind_reg       <= kind_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        mask_reg       <= mask_next;
        last_reg       <= last_next;
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.kind     = kind_reg;
    assign rsp.pixel_x  = px_reg;
    assign rsp.pixel_y  = py_reg;
    assign rsp.row_mask = mask_reg;
    assign rsp.last     = last_reg;

endmodule
